@@ hdl/entity_text_tokenizer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Text tokenizer assertion macros
// Shared concurrent check wrappers for the tokenizer modules
// ----------------------------------------------------------------------------
`ifndef ENTITY_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define ENTITY_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define ETT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ett_pkg.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer package
// Character codes, token kinds, result and run records, helpers
// ----------------------------------------------------------------------------
`default_nettype none

package ett_pkg;

  localparam int MAX_TOKEN_LEN = 1023;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int OUT_LEN_W     = 10;
  localparam int OUT_LEN_MAX   = 1023;
  localparam int RUN_MAX       = 3;
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_STRING = 2'd1,
    KIND_PUNCT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]           char_value;
    logic                 has_char;
    logic                 token_start;
    logic                 token_end;
    kind_t                token_kind;
    logic [OUT_LEN_W-1:0] token_length;
    logic                 end_of_text;
  } ett_res_t;

  // all results caused by one byte, slot 0 first
  typedef struct packed {
    ett_res_t [RUN_MAX-1:0] res;
    logic [1:0]             cnt;
  } ett_run_t;

  function automatic logic is_punct(logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_RPAREN) ||
           (c == CH_LPAREN) || (c == CH_APOS) || (c == CH_COLON);
  endfunction

  function automatic logic [OUT_LEN_W-1:0] sat_len(logic [LEN_W-1:0] len);
    logic [31:0] wide;
    wide = 32'(len);
    if (wide > 32'(OUT_LEN_MAX)) begin
      return OUT_LEN_W'(OUT_LEN_MAX);
    end
    return wide[OUT_LEN_W-1:0];
  endfunction

  function automatic ett_res_t mk_res(logic [7:0] ch, logic has, logic st, logic en,
                                      kind_t kind, logic [OUT_LEN_W-1:0] len,
                                      logic eot);
    ett_res_t r;
    r.char_value   = ch;
    r.has_char     = has;
    r.token_start  = st;
    r.token_end    = en;
    r.token_kind   = kind;
    r.token_length = len;
    r.end_of_text  = eot;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ett_if.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer channel interfaces
// Byte input channel and token result channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ett_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ett_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_value;
  logic       has_char;
  logic       token_start;
  logic       token_end;
  logic [1:0] token_kind;
  logic [9:0] token_length;
  logic       end_of_text;
  logic       last_of_run;

  modport source (output valid, output char_value, output has_char, output token_start,
                  output token_end, output token_kind, output token_length,
                  output end_of_text, output last_of_run, input ready);
  modport sink   (input valid, input char_value, input has_char, input token_start,
                  input token_end, input token_kind, input token_length,
                  input end_of_text, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/ett_front.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer front end
// Scans one byte per transfer and builds the run of results it causes
// ----------------------------------------------------------------------------
`default_nettype none

module ett_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       text_byte,
  output logic                  push,
  output ett_pkg::ett_run_t     push_run
);
  import ett_pkg::*;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_STRING  = 3'd4
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] len_inc;
  logic             ws, nul, punct;
  ett_run_t         run;

  assign ws      = (text_byte <= CH_SPACE);
  assign nul     = (text_byte == CH_NUL);
  assign punct   = is_punct(text_byte);
  assign len_inc = (len_r < LEN_W'(MAX_TOKEN_LEN)) ? len_r + LEN_W'(1) : len_r;

  always_comb begin
    ett_res_t eot_res, punct_res;
    eot_res   = mk_res(CH_NUL, 1'b0, 1'b0, 1'b0, KIND_WORD, '0, 1'b1);
    punct_res = mk_res(text_byte, 1'b1, 1'b1, 1'b1, KIND_PUNCT, OUT_LEN_W'(1), 1'b0);
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    run       = '0;
    case (mode_r)
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          // held slash opens a word; this byte continues it or ends it
          run.res[0] = mk_res(CH_SLASH, 1'b1, 1'b1, 1'b0, KIND_WORD, OUT_LEN_W'(1), 1'b0);
          if (punct) begin
            run.res[1] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b1, KIND_WORD, OUT_LEN_W'(1), 1'b0);
            run.res[2] = punct_res;
            run.cnt    = 2'd3;
            len_nxt    = LEN_W'(1);
            mode_nxt   = MODE_SKIP;
          end else if (ws) begin
            run.res[1] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b1, KIND_WORD, OUT_LEN_W'(1), nul);
            run.cnt    = 2'd2;
            len_nxt    = LEN_W'(1);
            mode_nxt   = MODE_SKIP;
          end else begin
            run.res[1] = mk_res(text_byte, 1'b1, 1'b0, 1'b0, KIND_WORD, OUT_LEN_W'(2), 1'b0);
            run.cnt    = 2'd2;
            len_nxt    = LEN_W'(2);
            mode_nxt   = MODE_WORD;
          end
        end
      end
      MODE_COMMENT: begin
        if (nul) begin
          run.res[0] = eot_res;
          run.cnt    = 2'd1;
          mode_nxt   = MODE_SKIP;
        end else if (text_byte == CH_NL) begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_WORD: begin
        if (punct) begin
          run.res[0] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b1, KIND_WORD, sat_len(len_r), 1'b0);
          run.res[1] = punct_res;
          run.cnt    = 2'd2;
          len_nxt    = LEN_W'(1);
          mode_nxt   = MODE_SKIP;
        end else if (ws) begin
          run.res[0] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b1, KIND_WORD, sat_len(len_r), nul);
          run.cnt    = 2'd1;
          mode_nxt   = MODE_SKIP;
        end else begin
          run.res[0] = mk_res(text_byte, 1'b1, 1'b0, 1'b0, KIND_WORD, sat_len(len_inc),
                              1'b0);
          run.cnt    = 2'd1;
          len_nxt    = len_inc;
        end
      end
      MODE_STRING: begin
        if ((text_byte == CH_QUOTE) || nul) begin
          run.res[0] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b1, KIND_STRING, sat_len(len_r), nul);
          run.cnt    = 2'd1;
          mode_nxt   = MODE_SKIP;
        end else begin
          run.res[0] = mk_res(text_byte, 1'b1, 1'b0, 1'b0, KIND_STRING, sat_len(len_inc),
                              1'b0);
          run.cnt    = 2'd1;
          len_nxt    = len_inc;
        end
      end
      default: begin
        mode_nxt = MODE_SKIP;
        if (nul) begin
          run.res[0] = eot_res;
          run.cnt    = 2'd1;
        end else if (ws) begin
          mode_nxt = MODE_SKIP;
        end else if (text_byte == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (text_byte == CH_QUOTE) begin
          run.res[0] = mk_res(CH_NUL, 1'b0, 1'b1, 1'b0, KIND_STRING, '0, 1'b0);
          run.cnt    = 2'd1;
          len_nxt    = '0;
          mode_nxt   = MODE_STRING;
        end else if (punct) begin
          run.res[0] = punct_res;
          run.cnt    = 2'd1;
          len_nxt    = LEN_W'(1);
        end else begin
          run.res[0] = mk_res(text_byte, 1'b1, 1'b1, 1'b0, KIND_WORD, OUT_LEN_W'(1), 1'b0);
          run.cnt    = 2'd1;
          len_nxt    = LEN_W'(1);
          mode_nxt   = MODE_WORD;
        end
      end
    endcase
  end

  assign push     = accept && (run.cnt != 2'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      len_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ett_queue.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer run queue
// Small FIFO of result runs between the scanner and the serialiser
// ----------------------------------------------------------------------------
`default_nettype none
`include "entity_text_tokenizer_unit_defines.svh"

module ett_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ett_pkg::ett_run_t push_run,
  input  wire logic              pop,
  output ett_pkg::ett_run_t      head,
  output logic                   empty,
  output logic                   full
);
  import ett_pkg::*;

  ett_run_t         store_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;

  function automatic logic [QAW-1:0] ptr_step(logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == (QAW + 1)'(QDEPTH));
  assign head  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_step(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_step(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAW + 1)'(1);
      end
    end
  end

  `ETT_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "push into full run queue")
  `ETT_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty run queue")
  `ETT_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
                   count_r == $past(count_r) + (QAW + 1)'(1), "run queue count lost a push")

endmodule

`default_nettype wire

@@ hdl/ett_back.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer back end
// Walks queued runs into the output register, one result per unstalled cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "entity_text_tokenizer_unit_defines.svh"

module ett_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ett_pkg::ett_run_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ett_pkg::ett_res_t      out_res,
  output logic                   out_last
);
  import ett_pkg::*;

  logic       out_valid_r;
  ett_res_t   out_res_r;
  logic       out_last_r;
  logic [1:0] idx_r;
  logic       load, is_last;

  assign load    = !empty && (!out_valid_r || out_ready);
  assign is_last = (idx_r == head.cnt - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  `ETT_ASSERT_NOW(a_idx_in_run, clk, rst_n, !empty,
                  (head.cnt != 2'd0) && (idx_r < head.cnt), "result index beyond queued run")
  `ETT_ASSERT_NEXT(a_idx_rewind, clk, rst_n, pop, idx_r == 2'd0,
                   "result index not rewound after run")

endmodule

`default_nettype wire

@@ hdl/entity_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// Text tokenizer unit
// Streams text bytes in, streams token characters and marks out
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_chan   in   valid / ready      text_byte
//  out_chan  out  valid / ready      char_value, has_char, token_start/end,
//                                    token_kind, token_length, end_of_text,
//                                    last_of_run
//
// A byte is taken every cycle while the run queue has room; a byte gives
// zero to three results and the serialiser sends one result per cycle while
// the output is not stalled. The first result of a byte passes through the
// run queue and then the output register. Reset is synchronous.
// Either side may stall; the four-entry run queue and the output register
// let the scanner keep going while results wait.
`default_nettype none

module entity_text_tokenizer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ett_in_if.sink     in_chan,
  ett_out_if.source  out_chan
);
  import ett_pkg::*;

  logic     accept;
  logic     push, pop, q_empty, q_full;
  ett_run_t push_run, head;
  ett_res_t out_res;
  logic     out_last;
  logic     out_valid;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  ett_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .text_byte(in_chan.text_byte),
    .push     (push),
    .push_run (push_run)
  );

  ett_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_run(push_run),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  ett_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_chan.ready),
    .out_res  (out_res),
    .out_last (out_last)
  );

  assign out_chan.valid        = out_valid;
  assign out_chan.char_value   = out_res.char_value;
  assign out_chan.has_char     = out_res.has_char;
  assign out_chan.token_start  = out_res.token_start;
  assign out_chan.token_end    = out_res.token_end;
  assign out_chan.token_kind   = out_res.token_kind;
  assign out_chan.token_length = out_res.token_length;
  assign out_chan.end_of_text  = out_res.end_of_text;
  assign out_chan.last_of_run  = out_last;

endmodule

`default_nettype wire
